// File: hw/rtl/dlbb_pkg.sv
// ----------------------------------------------------------------------------
// dlbb_pkg
// Shared constants, codes and controller/datapath types for the block
// completion bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlbb_pkg;

  // default number of mark bits
  localparam int unsigned MAX_BLOCKS = 1024;

  // fixed widths of the port fields
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned REG_LSB  = 2;

  // marks are stored as words of this many bits
  localparam int unsigned WORD_W = 32;
  localparam int unsigned WL     = $clog2(WORD_W);

  // dividend may carry one extra bit after the byte range end adjustment
  localparam int unsigned DVD_W = DATA_W + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET       = 3'd0,
    ACT_SET       = 3'd1,
    ACT_SET_ALL   = 3'd2,
    ACT_SET_RANGE = 3'd3,
    ACT_SET_BYTES = 3'd4,
    ACT_FIND      = 3'd5
  } dlbb_action_e;

  typedef enum logic {
    REG_TOTAL = 1'b0,
    REG_BPB   = 1'b1
  } dlbb_reg_e;

  typedef enum logic [1:0] {
    DIV_CNT = 2'd0,
    DIV_LO  = 2'd1,
    DIV_HI  = 2'd2
  } dlbb_div_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_CNT_GO,
    ST_CNT_WAIT,
    ST_IDLE,
    ST_DECODE,
    ST_LO_GO,
    ST_LO_WAIT,
    ST_HI_GO,
    ST_HI_WAIT,
    ST_PREP,
    ST_READ,
    ST_USE,
    ST_DONE
  } dlbb_state_e;

  typedef struct packed {
    logic          in_ready;
    logic          clr_start;
    logic          clr_write;
    logic          addr_inc;
    logic          div_start;
    dlbb_div_sel_e div_sel;
    logic          cnt_load;
    logic          lo_load;
    logic          hi_load;
    logic          prep;
    logic          rd_en;
    logic          word_op;
    logic          out_load;
  } dlbb_cmd_t;

  typedef struct packed {
    logic                in_fire;
    logic [ACTION_W-1:0] act;
    logic                div_done;
    logic                clr_last;
    logic                skip;
    logic                last_word;
    logic                hit;
    logic                out_busy;
  } dlbb_stat_t;

endpackage

// File: hw/rtl/dlbb_if.sv
// ----------------------------------------------------------------------------
// dlbb_in_if / dlbb_out_if
// Valid/ready channels carrying the request item and the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dlbb_in_if;
  logic                            valid;
  logic                            ready;
  logic [dlbb_pkg::ACTION_W-1:0]   action;
  logic [dlbb_pkg::DATA_W-1:0]     first;
  logic [dlbb_pkg::DATA_W-1:0]     last;
  logic                            bit_value;

  modport source (output valid, action, first, last, bit_value, input ready);
  modport sink   (input valid, action, first, last, bit_value, output ready);
endinterface

interface dlbb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          read_bit;
  logic [dlbb_pkg::POS_W-1:0]    found_position;
  logic [dlbb_pkg::POS_W-1:0]    block_count;
  logic                          status;

  modport source (output valid, read_bit, found_position, block_count, status, input ready);
  modport sink   (input valid, read_bit, found_position, block_count, status, output ready);
endinterface

// File: hw/rtl/dlbb_div.sv
// ----------------------------------------------------------------------------
// dlbb_div
// Restoring divider, one quotient bit per cycle, with a remainder-nonzero flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlbb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dlbb_pkg::DVD_W-1:0]    dividend_i,
  input  logic [dlbb_pkg::DATA_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [dlbb_pkg::DVD_W-1:0]    quo_o,
  output logic                          rem_nz_o
);
  import dlbb_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DATA_W:0]     rem_q, rem_d;
  logic [DVD_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]   dsr_q, dsr_d;

  logic [DATA_W:0]     shifted;
  logic [DATA_W+1:0]   diff;
  logic                ge;

  always_comb begin
    shifted = {rem_q[DATA_W-1:0], quo_q[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    ge      = ~diff[DATA_W+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DATA_W:0] : shifted;
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

// File: hw/rtl/dlbb_dp.sv
// ----------------------------------------------------------------------------
// dlbb_dp
// Datapath: config registers, block count, range decode, word-wide mark
// memory, match search and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlbb_dp #(
  parameter int unsigned MaxBlocks = dlbb_pkg::MAX_BLOCKS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dlbb_in_if.sink                       in_ch,
  dlbb_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [dlbb_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [dlbb_pkg::DATA_W-1:0]   cfg_wdata_i,
  output logic [dlbb_pkg::DATA_W-1:0]   cfg_rdata_o,
  input  dlbb_pkg::dlbb_cmd_t           cmd_i,
  output dlbb_pkg::dlbb_stat_t          stat_o
);
  import dlbb_pkg::*;

  localparam int unsigned CW     = $clog2(MaxBlocks + 1);
  localparam int unsigned NWORDS = (MaxBlocks + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned PW     = (CW > WL + AW) ? CW : WL + AW;

  // config registers
  logic [DATA_W-1:0] total_q, bpb_q;
  dlbb_reg_e         reg_sel;

  assign reg_sel     = dlbb_reg_e'(cfg_addr_i[REG_LSB]);
  assign cfg_rdata_o = (reg_sel == REG_BPB) ? bpb_q : total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      bpb_q   <= DATA_W'(1);
    end else if (cfg_we_i) begin
      if (reg_sel == REG_BPB) begin
        bpb_q <= cfg_wdata_i;
      end else begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  // latched item
  logic [ACTION_W-1:0] act_q;
  logic [DATA_W-1:0]   first_q, last_q;
  logic                val_q;
  logic                in_fire;

  assign in_ch.ready = cmd_i.in_ready;
  assign in_fire     = in_ch.valid & cmd_i.in_ready;

  // division operands
  logic [DATA_W-1:0] blk;
  logic [DVD_W-1:0]  last_adj;
  logic [DVD_W-1:0]  div_dvd;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic              div_rem_nz;

  assign blk = (bpb_q == '0) ? DATA_W'(1) : bpb_q;

  // an end at or past the length also covers the final partial block
  assign last_adj = (last_q >= total_q) ? ({1'b0, last_q} + {1'b0, blk})
                                        : {1'b0, last_q};

  always_comb begin
    case (cmd_i.div_sel)
      DIV_LO:  div_dvd = {1'b0, first_q};
      DIV_HI:  div_dvd = last_adj;
      default: div_dvd = {1'b0, total_q};
    endcase
  end

  dlbb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (blk),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_nz_o   (div_rem_nz)
  );

  // block count, ceiling and saturation
  logic [CW-1:0]    n_q;
  logic [DVD_W:0]   cnt_sum;
  logic [CW-1:0]    n_d;

  assign cnt_sum = {1'b0, div_quo} + (DVD_W + 1)'(div_rem_nz);
  assign n_d     = (cnt_sum > (DVD_W + 1)'(MaxBlocks)) ? CW'(MaxBlocks) : cnt_sum[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.cnt_load) begin
      n_q <= n_d;
    end
  end

  // raw range bounds, clamped in the prep step
  logic [DVD_W-1:0] lo_raw_q, hi_raw_q;
  logic [DVD_W-1:0] n_ext, lo_c, lo_e, hi_e, hm1_e;
  logic             hi_gt, first_oor, empty, is_pt, skip;

  assign n_ext = DVD_W'(n_q);

  always_comb begin
    first_oor = {1'b0, first_q} >= n_ext;
    lo_c      = (lo_raw_q >= n_ext) ? n_ext : lo_raw_q;
    hi_gt     = hi_raw_q > n_ext;
    hi_e      = hi_gt ? n_ext : hi_raw_q;
    lo_e      = lo_c;
    // an end beyond the count still writes the final mark
    if (hi_gt && (n_q != '0) && (lo_c == n_ext)) begin
      lo_e = n_ext - DVD_W'(1);
    end
    empty = hi_e <= lo_e;
    hm1_e = hi_e - DVD_W'(1);
    is_pt = (act_q == ACT_GET) || (act_q == ACT_SET);
    skip  = is_pt ? first_oor : empty;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= in_ch.action;
      first_q <= in_ch.first;
      last_q  <= in_ch.last;
      val_q   <= in_ch.bit_value;
      case (in_ch.action)
        ACT_SET, ACT_GET: begin
          lo_raw_q <= {1'b0, in_ch.first};
          hi_raw_q <= {1'b0, in_ch.first} + DVD_W'(1);
        end
        ACT_SET_ALL: begin
          lo_raw_q <= '0;
          hi_raw_q <= n_ext;
        end
        ACT_SET_RANGE: begin
          lo_raw_q <= {1'b0, in_ch.first};
          hi_raw_q <= {1'b0, in_ch.last};
        end
        default: begin
          lo_raw_q <= {1'b0, in_ch.first};
          hi_raw_q <= n_ext;
        end
      endcase
    end else begin
      if (cmd_i.lo_load) begin
        lo_raw_q <= div_quo;
      end
      if (cmd_i.hi_load) begin
        hi_raw_q <= div_quo;
      end
    end
  end

  // word walk
  logic [PW-1:0]     lo_q, hm1_q;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     lo_word, hi_word;
  logic [WL-1:0]     start, stop;
  logic [WORD_W-1:0] mask, wdata, match, rdata_q;
  logic [WL-1:0]     ffs_idx;
  logic              is_lo, is_hi, hit, is_wr_act;
  logic [PW-1:0]     pos;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      lo_q  <= lo_e[PW-1:0];
      hm1_q <= hm1_e[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.clr_start) begin
      addr_q <= '0;
    end else if (cmd_i.prep) begin
      addr_q <= lo_e[WL+AW-1:WL];
    end else if (cmd_i.addr_inc) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  always_comb begin
    lo_word = lo_q[WL+AW-1:WL];
    hi_word = hm1_q[WL+AW-1:WL];
    is_lo   = addr_q == lo_word;
    is_hi   = addr_q == hi_word;
    start   = is_lo ? lo_q[WL-1:0] : '0;
    stop    = is_hi ? hm1_q[WL-1:0] : {WL{1'b1}};
    mask    = ({WORD_W{1'b1}} << start) & ({WORD_W{1'b1}} >> (~stop));
    wdata   = (rdata_q & ~mask) | (val_q ? mask : '0);
    match   = (val_q ? rdata_q : ~rdata_q) & mask;
    hit     = |match;
    is_wr_act = (act_q == ACT_SET) || (act_q == ACT_SET_ALL) ||
                (act_q == ACT_SET_RANGE) || (act_q == ACT_SET_BYTES);
  end

  always_comb begin
    ffs_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (match[j]) begin
        ffs_idx = WL'(j);
      end
    end
  end

  assign pos = PW'({addr_q, ffs_idx});

  // mark memory, one word per row
  logic [WORD_W-1:0] mem_q [NWORDS];
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  assign mem_we    = cmd_i.clr_write | (cmd_i.word_op & is_wr_act);
  assign mem_wdata = cmd_i.clr_write ? '0 : wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // result being built
  logic          res_rd_q;
  logic [CW-1:0] res_found_q;
  logic          res_status_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_rd_q     <= 1'b0;
      res_found_q  <= '0;
      res_status_q <= in_ch.action > ACT_FIND;
    end else if (cmd_i.prep) begin
      if (is_pt && first_oor) begin
        res_status_q <= 1'b1;
      end
      if (act_q == ACT_FIND) begin
        res_found_q <= n_q;
      end
    end else if (cmd_i.word_op) begin
      if (act_q == ACT_GET) begin
        res_rd_q <= rdata_q[lo_q[WL-1:0]];
      end
      if ((act_q == ACT_FIND) && hit) begin
        res_found_q <= pos[CW-1:0];
      end
    end
  end

  // output register
  logic                out_valid_q;
  logic                out_rd_q, out_status_q;
  logic [POS_W-1:0]    out_found_q, out_count_q;
  logic [CW+POS_W-1:0] found_ext, count_ext;

  assign found_ext = {{POS_W{1'b0}}, res_found_q};
  assign count_ext = {{POS_W{1'b0}}, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rd_q     <= res_rd_q;
      out_found_q  <= found_ext[POS_W-1:0];
      out_count_q  <= count_ext[POS_W-1:0];
      out_status_q <= res_status_q;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.read_bit       = out_rd_q;
  assign out_ch.found_position = out_found_q;
  assign out_ch.block_count    = out_count_q;
  assign out_ch.status         = out_status_q;

  always_comb begin
    stat_o           = '0;
    stat_o.in_fire   = in_fire;
    stat_o.act       = act_q;
    stat_o.div_done  = div_done;
    stat_o.clr_last  = addr_q == AW'(NWORDS - 1);
    stat_o.skip      = skip;
    stat_o.last_word = is_hi;
    stat_o.hit       = hit;
    stat_o.out_busy  = out_valid_q & ~out_ch.ready;
  end

endmodule

// File: hw/rtl/dlbb_ctrl.sv
// ----------------------------------------------------------------------------
// dlbb_ctrl
// Sequencer: clearing pass, block count, per-item divide, word walk and
// result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlbb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  dlbb_pkg::dlbb_stat_t  stat_i,
  output dlbb_pkg::dlbb_cmd_t   cmd_o
);
  import dlbb_pkg::*;

  dlbb_state_e state_q, state_d;
  logic        is_get, is_find;

  assign is_get  = stat_i.act == ACT_GET;
  assign is_find = stat_i.act == ACT_FIND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (stat_i.clr_last) state_d = ST_CNT_GO;
      ST_CNT_GO:   state_d = ST_CNT_WAIT;
      ST_CNT_WAIT: if (stat_i.div_done) state_d = ST_IDLE;
      ST_IDLE:     if (stat_i.in_fire) state_d = ST_DECODE;
      ST_DECODE: begin
        case (stat_i.act)
          ACT_GET, ACT_SET, ACT_SET_ALL, ACT_SET_RANGE, ACT_FIND: state_d = ST_PREP;
          ACT_SET_BYTES: state_d = ST_LO_GO;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_LO_GO:    state_d = ST_LO_WAIT;
      ST_LO_WAIT:  if (stat_i.div_done) state_d = ST_HI_GO;
      ST_HI_GO:    state_d = ST_HI_WAIT;
      ST_HI_WAIT:  if (stat_i.div_done) state_d = ST_PREP;
      ST_PREP:     state_d = stat_i.skip ? ST_DONE : ST_READ;
      ST_READ:     state_d = ST_USE;
      ST_USE: begin
        if (is_get || stat_i.last_word || (is_find && stat_i.hit)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_DONE:     if (!stat_i.out_busy) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
    // new sizing restarts the clearing pass
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_CNT;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        cmd_o.addr_inc  = 1'b1;
      end
      ST_CNT_GO:   cmd_o.div_start = 1'b1;
      ST_CNT_WAIT: cmd_o.cnt_load  = stat_i.div_done;
      ST_IDLE:     cmd_o.in_ready  = ~cfg_we_i;
      ST_LO_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_LO;
      end
      ST_LO_WAIT:  cmd_o.lo_load = stat_i.div_done;
      ST_HI_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_HI;
      end
      ST_HI_WAIT:  cmd_o.hi_load = stat_i.div_done;
      ST_PREP:     cmd_o.prep    = 1'b1;
      ST_READ:     cmd_o.rd_en   = 1'b1;
      ST_USE: begin
        cmd_o.word_op  = 1'b1;
        cmd_o.addr_inc = ~(is_get || stat_i.last_word || (is_find && stat_i.hit));
      end
      ST_DONE:     cmd_o.out_load = ~stat_i.out_busy;
      default:     cmd_o.in_ready = 1'b0;
    endcase
    if (cfg_we_i) begin
      cmd_o.clr_start = 1'b1;
    end
  end

endmodule

// File: hw/rtl/download_block_bitmap.sv
// ----------------------------------------------------------------------------
// download_block_bitmap
// One mark bit per fixed-size block of a download, with get, set, range set
// and find-first on a valid/ready channel and an APB sizing port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Marks live in a single-port memory of 32-bit words, walked by a sequencer
// one word at a time (read, then merge or search). Get and set touch a
// single word; set all, block range and byte range walk the words of the
// range, and find stops at the first word holding a match. An item that
// touches no word skips the walk, and an unknown action goes straight to
// the result. A byte range runs two divides ahead of the walk. After reset
// and after any register write the block runs a clearing pass over all
// words and a divide for the block count, and it accepts no item until
// both are done. One item is worked on at a time; a finished result waits
// in an output register while the next item is taken.

module download_block_bitmap #(
  parameter int unsigned MaxBlocks = dlbb_pkg::MAX_BLOCKS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dlbb_in_if.sink                       in_ch,
  dlbb_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlbb_pkg::CFG_AW-1:0]   paddr,
  input  logic [dlbb_pkg::DATA_W-1:0]   pwdata,
  output logic [dlbb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import dlbb_pkg::*;

  dlbb_cmd_t  cmd;
  dlbb_stat_t stat;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  dlbb_dp #(
    .MaxBlocks (MaxBlocks)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (paddr),
    .cfg_wdata_i (pwdata),
    .cfg_rdata_o (prdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  dlbb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

endmodule

// File: hw/rtl/dlbb_chk.sv
// ----------------------------------------------------------------------------
// dlbb_chk
// Port-level checks on the result channel and sizing writes, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlbb_chk #(
  parameter int unsigned MaxBlocks = dlbb_pkg::MAX_BLOCKS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        read_bit_i,
  input logic [dlbb_pkg::POS_W-1:0]  found_i,
  input logic [dlbb_pkg::POS_W-1:0]  count_i,
  input logic                        status_i,
  input logic                        cfg_wr_i
);
  import dlbb_pkg::*;

  localparam bit NoWrap = MaxBlocks < (1 << POS_W);

  // a stalled item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(read_bit_i) && $stable(found_i) &&
                                    $stable(count_i) && $stable(status_i))
    else $error("result changed while stalled");

  // only an in-range get returns a set bit
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && read_bit_i |-> !status_i && (found_i == '0))
    else $error("read bit with error or find position");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && NoWrap |-> (found_i <= count_i) && (count_i <= MaxBlocks))
    else $error("position or count out of bounds");

  // resizing starts a clearing pass
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> !in_ready_i)
    else $error("item taken right after a register write");

endmodule

bind download_block_bitmap dlbb_chk #(
  .MaxBlocks (MaxBlocks)
) u_dlbb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .read_bit_i  (out_ch.read_bit),
  .found_i     (out_ch.found_position),
  .count_i     (out_ch.block_count),
  .status_i    (out_ch.status),
  .cfg_wr_i    (psel && penable && pwrite)
);
